// File: hw/rtl/iqbm_pkg.sv
package iqbm_pkg;

    // fixed field widths
    localparam int SAMPLE_W     = 16;
    localparam int RF_W         = 18;
    localparam int TRIG_PHASE_W = 32;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 32;

    // default build parameters
    localparam int DEF_PHASE_BITS  = 32;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_TRIG_STAGES = 16;
    localparam int QUEUE_DEPTH     = 2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_OFFSET    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_QUAD_PHASE_SKEW = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_QUAD_GAIN       = 8'd3;

    // register reset values
    localparam logic [31:0] RST_PHASE_STEP      = 32'd0;
    localparam logic [15:0] RST_PHASE_OFFSET    = 16'd0;
    localparam logic [15:0] RST_QUAD_PHASE_SKEW = 16'd0;
    localparam logic [15:0] RST_QUAD_GAIN       = 16'd16384;

    // output saturation limits
    localparam logic signed [RF_W-1:0] RF_MAX = 18'sd131071;
    localparam logic signed [RF_W-1:0] RF_MIN = -18'sd131072;

    // cordic start vector, 2^30 divided by the cordic gain
    localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

    // arctan(2^-i) as fraction of a cycle times 2^32
    localparam logic [31:0] ATAN_TAB [24] = '{
        32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    // carrier settings seen by the front end
    typedef struct packed {
        logic [31:0]        phase_step;
        logic [15:0]        phase_offset;
        logic signed [15:0] quad_phase_skew;
    } carrier_cfg_t;

    // one queued sample with its two trig phases
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] i_sample;
        logic signed [SAMPLE_W-1:0] q_sample;
        logic [TRIG_PHASE_W-1:0]    phase_i;
        logic [TRIG_PHASE_W-1:0]    phase_q;
    } queue_item_t;

endpackage

// File: hw/rtl/iqbm_front.sv
module iqbm_front #(
    parameter int PHASE_BITS = iqbm_pkg::DEF_PHASE_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [iqbm_pkg::SAMPLE_W-1:0] s_i_sample,
    input  logic signed [iqbm_pkg::SAMPLE_W-1:0] s_q_sample,
    input  iqbm_pkg::carrier_cfg_t               carrier_cfg,
    input  logic                                 queue_full,
    output logic                                 queue_push,
    output iqbm_pkg::queue_item_t                queue_item
);

    logic [PHASE_BITS-1:0]                 carrier_phase_reg;
    logic [PHASE_BITS-1:0]                 carrier_phase_next;
    logic [PHASE_BITS-1:0]                 step_aligned;
    logic [iqbm_pkg::TRIG_PHASE_W-1:0]     phase_top;
    logic [iqbm_pkg::TRIG_PHASE_W-1:0]     phase_i;

    // align accumulator and step to a 32-bit trig phase
    if (PHASE_BITS >= 32) begin : g_wide
        assign phase_top    = carrier_phase_reg[PHASE_BITS-1 -: 32];
        assign step_aligned = PHASE_BITS'(carrier_cfg.phase_step) << (PHASE_BITS - 32);
    end else begin : g_narrow
        assign phase_top    = 32'(carrier_phase_reg) << (32 - PHASE_BITS);
        assign step_aligned = PHASE_BITS'(carrier_cfg.phase_step >> (32 - PHASE_BITS));
    end

    // branch phases
    assign phase_i = phase_top + {carrier_cfg.phase_offset, 16'd0};

    always_comb begin
        queue_item.i_sample = s_i_sample;
        queue_item.q_sample = s_q_sample;
        queue_item.phase_i  = phase_i;
        queue_item.phase_q  = phase_i + {carrier_cfg.quad_phase_skew, 16'd0};
    end

    // accept while the queue has room
    assign s_ready    = !queue_full;
    assign queue_push = s_valid && s_ready;

    assign carrier_phase_next = carrier_phase_reg + step_aligned;

    // carrier phase accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carrier_phase_reg <= '0;
        end else if (queue_push) begin
            carrier_phase_reg <= carrier_phase_next;
        end
    end

endmodule

// File: hw/rtl/iqbm_queue.sv
module iqbm_queue #(
    parameter int DEPTH = iqbm_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  iqbm_pkg::queue_item_t push_item,
    output logic                  full,
    input  logic                  pop,
    output iqbm_pkg::queue_item_t pop_item,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    iqbm_pkg::queue_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/iqbm_cordic.sv
module iqbm_cordic #(
    parameter int SAMPLE_BITS = iqbm_pkg::DEF_SAMPLE_BITS,
    parameter int TRIG_STAGES = iqbm_pkg::DEF_TRIG_STAGES
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [iqbm_pkg::TRIG_PHASE_W-1:0]      phase,
    input  logic                                   want_sin,
    output logic                                   done,
    output logic signed [SAMPLE_BITS+1:0]          trig_val
);

    localparam int IW = $clog2(TRIG_STAGES);
    localparam int CW = SAMPLE_BITS + 2;
    localparam int RS = 30 - SAMPLE_BITS;
    localparam logic signed [32:0] HALF = 33'sd1 <<< (RS - 1);

    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic signed [32:0] z_reg;
    logic               neg_reg;
    logic [IW-1:0]      iter_reg;
    logic               run_reg;
    logic               done_reg;

    logic [31:0]        phase_fold;
    logic               phase_neg;
    logic [4:0]         atan_idx;
    logic signed [32:0] atan_val;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] sel_val;
    logic signed [31:0] sel_signed;
    logic signed [32:0] rnd_sum;

    // fold second and third quadrant by half a cycle
    assign phase_neg  = phase[31] ^ phase[30];
    assign phase_fold = {phase[31] ^ phase_neg, phase[30:0]};

    // one micro-rotation
    assign atan_idx = 5'(iter_reg);
    assign atan_val = $signed({1'b0, iqbm_pkg::ATAN_TAB[atan_idx]});
    assign dx       = y_reg >>> iter_reg;
    assign dy       = x_reg >>> iter_reg;

    // undo fold and round to SAMPLE_BITS fraction bits
    assign sel_val    = want_sin ? y_reg : x_reg;
    assign sel_signed = neg_reg ? -sel_val : sel_val;
    assign rnd_sum    = 33'(sel_signed) + HALF;
    assign trig_val   = CW'(rnd_sum >>> RS);
    assign done       = done_reg;

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                iter_reg <= '0;
            end else if (run_reg) begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == IW'(TRIG_STAGES - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // rotation datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= iqbm_pkg::CORDIC_X0;
            y_reg   <= '0;
            z_reg   <= 33'($signed(phase_fold));
            neg_reg <= phase_neg;
        end else if (run_reg) begin
            if (!z_reg[32]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_val;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_val;
            end
        end
    end

endmodule

// File: hw/rtl/iqbm_back.sv
module iqbm_back #(
    parameter int SAMPLE_BITS = iqbm_pkg::DEF_SAMPLE_BITS,
    parameter int TRIG_STAGES = iqbm_pkg::DEF_TRIG_STAGES
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 item_valid,
    input  iqbm_pkg::queue_item_t                item,
    output logic                                 item_ready,
    input  logic [15:0]                          quad_gain,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [iqbm_pkg::RF_W-1:0]     m_rf_sample
);

    localparam int CW  = SAMPLE_BITS + 2;
    localparam int TIW = iqbm_pkg::SAMPLE_W + CW;
    localparam int QGW = 33;
    localparam int PQW = QGW + CW;
    localparam int PQS = PQW + 1;
    localparam int TQW = PQS - 14;
    localparam int DW  = TQW + 1;
    localparam int DS  = DW + 1;
    localparam int RW  = DS - SAMPLE_BITS;
    localparam logic signed [PQS-1:0] HALF_Q = PQS'(1) <<< 13;
    localparam logic signed [DS-1:0]  HALF_D = DS'(1) <<< (SAMPLE_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIG,
        ST_MUL1,
        ST_MUL2,
        ST_RND1,
        ST_RND2,
        ST_DONE
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;

    logic signed [iqbm_pkg::SAMPLE_W-1:0] i_reg;
    logic signed [iqbm_pkg::SAMPLE_W-1:0] q_reg;
    logic signed [CW-1:0]                 ci_reg;
    logic signed [CW-1:0]                 sq_reg;
    logic signed [TIW-1:0]                ti_reg;
    logic signed [QGW-1:0]                qg_reg;
    logic signed [PQW-1:0]                pq_reg;
    logic signed [TQW-1:0]                tq_reg;
    logic signed [DW-1:0]                 d_reg;
    logic                                 m_valid_reg;
    logic signed [iqbm_pkg::RF_W-1:0]     m_rf_sample_reg;

    logic                                 trig_start;
    logic                                 done_i;
    logic                                 done_q;
    logic signed [CW-1:0]                 cos_i;
    logic signed [CW-1:0]                 sin_q;
    logic signed [PQS-1:0]                tq_sum;
    logic signed [DS-1:0]                 r_sum;
    logic signed [RW-1:0]                 r_val;
    logic signed [iqbm_pkg::RF_W-1:0]     rf_sat;
    logic                                 out_free;

    assign item_ready = (state_reg == ST_IDLE);
    assign trig_start = item_ready && item_valid;
    assign out_free   = !m_valid_reg || m_ready;

    // in-phase branch cosine and quadrature branch sine
    iqbm_cordic #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TRIG_STAGES (TRIG_STAGES)
    ) u_cordic_i (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (trig_start),
        .phase    (item.phase_i),
        .want_sin (1'b0),
        .done     (done_i),
        .trig_val (cos_i)
    );

    iqbm_cordic #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TRIG_STAGES (TRIG_STAGES)
    ) u_cordic_q (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (trig_start),
        .phase    (item.phase_q),
        .want_sin (1'b1),
        .done     (done_q),
        .trig_val (sin_q)
    );

    // rounding and saturation
    assign tq_sum = PQS'(pq_reg) + HALF_Q;
    assign r_sum  = DS'(d_reg) + HALF_D;
    assign r_val  = RW'(r_sum >>> SAMPLE_BITS);

    always_comb begin
        if (r_val > RW'(iqbm_pkg::RF_MAX)) begin
            rf_sat = iqbm_pkg::RF_MAX;
        end else if (r_val < RW'(iqbm_pkg::RF_MIN)) begin
            rf_sat = iqbm_pkg::RF_MIN;
        end else begin
            rf_sat = r_val[iqbm_pkg::RF_W-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (item_valid) state_next = ST_TRIG;
            ST_TRIG: if (done_i && done_q) state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_RND1;
            ST_RND1: state_next = ST_RND2;
            ST_RND2: state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // state, datapath and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    i_reg <= item.i_sample;
                    q_reg <= item.q_sample;
                end
                ST_TRIG: begin
                    ci_reg <= cos_i;
                    sq_reg <= sin_q;
                end
                ST_MUL1: begin
                    ti_reg <= TIW'(i_reg) * TIW'(ci_reg);
                    qg_reg <= QGW'(q_reg) * $signed({17'd0, quad_gain});
                end
                ST_MUL2: pq_reg <= PQW'(qg_reg) * PQW'(sq_reg);
                ST_RND1: tq_reg <= TQW'(tq_sum >>> 14);
                ST_RND2: d_reg  <= DW'(ti_reg) - DW'(tq_reg);
                ST_DONE: begin
                    if (out_free) begin
                        m_rf_sample_reg <= rf_sat;
                        m_valid_reg     <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_rf_sample = m_rf_sample_reg;

endmodule

// File: hw/rtl/iq_bandpass_modulator_unit.sv
// channel   dir  handshake            payload
// s_        in   s_valid / s_ready    s_i_sample[15:0], s_q_sample[15:0]
// m_        out  m_valid / m_ready    m_rf_sample[17:0]
// cfg_      in   cfg_valid/cfg_ready  cfg_index[7:0], cfg_data[31:0]
//
// each sample passes through the iterative cordic pair in the back end, then
// through its multiply and rounding steps
// the front end takes up to two beats ahead into the queue while the back works
// aresetn is synchronous: carrier phase to zero, registers to defaults, queue empty
// a stalled result waits in the output register; the back end holds until it is free
module iq_bandpass_modulator_unit #(
    parameter int PHASE_BITS  = iqbm_pkg::DEF_PHASE_BITS,
    parameter int SAMPLE_BITS = iqbm_pkg::DEF_SAMPLE_BITS,
    parameter int TRIG_STAGES = iqbm_pkg::DEF_TRIG_STAGES
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [iqbm_pkg::SAMPLE_W-1:0]    s_i_sample,
    input  logic signed [iqbm_pkg::SAMPLE_W-1:0]    s_q_sample,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [iqbm_pkg::RF_W-1:0]        m_rf_sample,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [iqbm_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [iqbm_pkg::CFG_DATA_W-1:0]         cfg_data
);

    iqbm_pkg::carrier_cfg_t carrier_cfg_reg;
    logic [15:0]            quad_gain_reg;

    logic                   queue_push;
    logic                   queue_pop;
    logic                   queue_full;
    logic                   queue_empty;
    logic                   back_ready;
    iqbm_pkg::queue_item_t  push_item;
    iqbm_pkg::queue_item_t  pop_item;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carrier_cfg_reg.phase_step      <= iqbm_pkg::RST_PHASE_STEP;
            carrier_cfg_reg.phase_offset    <= iqbm_pkg::RST_PHASE_OFFSET;
            carrier_cfg_reg.quad_phase_skew <= iqbm_pkg::RST_QUAD_PHASE_SKEW;
            quad_gain_reg                   <= iqbm_pkg::RST_QUAD_GAIN;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                iqbm_pkg::REG_PHASE_STEP:
                    carrier_cfg_reg.phase_step <= cfg_data;
                iqbm_pkg::REG_PHASE_OFFSET:
                    carrier_cfg_reg.phase_offset <= cfg_data[15:0];
                iqbm_pkg::REG_QUAD_PHASE_SKEW:
                    carrier_cfg_reg.quad_phase_skew <= cfg_data[15:0];
                iqbm_pkg::REG_QUAD_GAIN:
                    quad_gain_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // front: phase accumulator and item build
    iqbm_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_i_sample  (s_i_sample),
        .s_q_sample  (s_q_sample),
        .carrier_cfg (carrier_cfg_reg),
        .queue_full  (queue_full),
        .queue_push  (queue_push),
        .queue_item  (push_item)
    );

    // queue between front and back
    iqbm_queue #(
        .DEPTH (iqbm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (queue_push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    assign queue_pop = back_ready && !queue_empty;

    // back: trig, mixing and output register
    iqbm_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TRIG_STAGES (TRIG_STAGES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (!queue_empty),
        .item        (pop_item),
        .item_ready  (back_ready),
        .quad_gain   (quad_gain_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rf_sample (m_rf_sample)
    );

    // reset leaves no result pending and the queue not full
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !queue_full)
        else $error("reset did not clear output or queue");

    // the back end works on one sample at a time
    a_single_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        queue_pop |=> !queue_pop)
        else $error("back end popped two samples in a row");

    // an accepted beat is held in the queue
    a_beat_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !queue_pop |=> !queue_empty)
        else $error("accepted beat missing from queue");

endmodule
